// File: sv/cdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared types and constants for the character display dirty refresh core.
// ----------------------------------------------------------------------------
package cdr_pkg;

   // Item field widths
   localparam int ROW_W  = 1;
   localparam int COL_W  = 4;
   localparam int CHAR_W = 8;

   // Request kinds
   localparam logic KIND_STORE   = 1'b0;
   localparam logic KIND_REFRESH = 1'b1;

   // Display command codes
   localparam logic CMD_CURSOR = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   // Reset contents of every cell
   localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic wr_cell;      // store the request character into wanted text
      logic scan_start;   // rewind the scan to the first cell
      logic scan_read;    // read both stores at the scan cell
      logic scan_check;   // compare the read cell, update shown text
      logic emit_cursor;  // queue a cursor command for the scan cell
      logic emit_write;   // queue a write command and step the scan
      logic flush;        // release the held command marked last
   } cdr_ctrl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic differ;       // scan cell changed since last refresh
      logic cursor_here;  // display cursor already sits on the scan cell
      logic last_cell;    // scan cell is the final cell of the grid
      logic push_ok;      // a new command can be queued this cycle
      logic pend_valid;   // a command is held back for the last flag
      logic out_free;     // output register can load this cycle
   } cdr_stat_type;

endpackage
`default_nettype wire

// File: sv/cdr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_req_if / cdr_rsp_if
// Valid/ready channels carrying request items and display command items.
// ----------------------------------------------------------------------------
interface cdr_req_if;
   import cdr_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  col;
   logic [CHAR_W-1:0] char_code;

   modport source (output valid, kind, row, col, char_code, input ready);
   modport sink   (input valid, kind, row, col, char_code, output ready);
endinterface

interface cdr_rsp_if;
   import cdr_pkg::*;
   logic              valid;
   logic              ready;
   logic              command;
   logic [ROW_W-1:0]  cursor_row;
   logic [COL_W-1:0]  cursor_col;
   logic [CHAR_W-1:0] out_char;
   logic              last;

   modport source (output valid, command, cursor_row, cursor_col, out_char, last,
                   input ready);
   modport sink   (input valid, command, cursor_row, cursor_col, out_char, last,
                   output ready);
endinterface
`default_nettype wire

// File: sv/cdr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/cdr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_datapath
// Wanted and shown text stores, scan counters, cursor tracking, a one-deep
// hold stage that lets the final command carry the last flag, and the
// output register.
// ----------------------------------------------------------------------------
module cdr_datapath
   import cdr_pkg::*;
#(
   parameter int ROWS = 2,
   parameter int COLS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cdr_ctrl_type      ctrl,
   output cdr_stat_type           stat,
   input  wire logic [ROW_W-1:0]  req_row,
   input  wire logic [COL_W-1:0]  req_col,
   input  wire logic [CHAR_W-1:0] req_char_code,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_command,
   output logic [ROW_W-1:0]       rsp_cursor_row,
   output logic [COL_W-1:0]       rsp_cursor_col,
   output logic [CHAR_W-1:0]      rsp_out_char,
   output logic                   rsp_last
);

   localparam int CELLS = ROWS * COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW    = $clog2(COLS);

   // Cell valid bits: a cell never written reads as a space
   logic [CELLS-1:0] wanted_vld_ff, wanted_vld_in;
   logic [CELLS-1:0] shown_vld_ff, shown_vld_in;
   logic             wanted_vld_rd_ff, shown_vld_rd_ff;

   // Scan position and cursor tracking
   logic [AW-1:0] addr_ff, addr_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic          cursor_here_ff, cursor_here_in;
   logic [CHAR_W-1:0] char_ff;

   // Held command
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_cmd_ff;
   logic [ROW_W-1:0]  pend_row_ff;
   logic [COL_W-1:0]  pend_col_ff;
   logic [CHAR_W-1:0] pend_char_ff;

   // Output register
   logic              out_valid_ff, out_valid_in;
   logic              out_cmd_ff;
   logic [ROW_W-1:0]  out_row_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [CHAR_W-1:0] out_char_ff;
   logic              out_last_ff;

   logic [AW-1:0]     wr_addr;
   logic              wr_in_grid;
   logic [CHAR_W-1:0] wanted_rd, shown_rd;
   logic [CHAR_W-1:0] wanted_char, shown_char;
   logic              end_of_row, out_free, push, emit, out_load;

   // Map the request cell to a store address
   assign wr_in_grid = (32'(req_row) < 32'(ROWS)) && (32'(req_col) < 32'(COLS));
   assign wr_addr    = AW'(req_row) * AW'(COLS) + AW'(req_col);

   cdr_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_wanted_ram (
      .clock   (clock),
      .wr_en   (ctrl.wr_cell && wr_in_grid),
      .wr_addr (wr_addr),
      .wr_data (req_char_code),
      .rd_en   (ctrl.scan_read),
      .rd_addr (addr_ff),
      .rd_data (wanted_rd)
   );

   cdr_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_shown_ram (
      .clock   (clock),
      .wr_en   (ctrl.scan_check && stat.differ),
      .wr_addr (addr_ff),
      .wr_data (wanted_char),
      .rd_en   (ctrl.scan_read),
      .rd_addr (addr_ff),
      .rd_data (shown_rd)
   );

   // Mark cells as written
   always_comb begin
      wanted_vld_in = wanted_vld_ff;
      shown_vld_in  = shown_vld_ff;
      if (ctrl.wr_cell && wr_in_grid) begin
         wanted_vld_in[wr_addr] = 1'b1;
      end
      if (ctrl.scan_check && stat.differ) begin
         shown_vld_in[addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_vld_ff <= '0;
         shown_vld_ff  <= '0;
      end else begin
         wanted_vld_ff <= wanted_vld_in;
         shown_vld_ff  <= shown_vld_in;
      end
   end

   // Sample valid bits alongside the RAM read
   always_ff @(posedge clock) begin
      if (ctrl.scan_read) begin
         wanted_vld_rd_ff <= wanted_vld_ff[addr_ff];
         shown_vld_rd_ff  <= shown_vld_ff[addr_ff];
      end
   end

   assign wanted_char = wanted_vld_rd_ff ? wanted_rd : SPACE_CHAR;
   assign shown_char  = shown_vld_rd_ff  ? shown_rd  : SPACE_CHAR;

   // Advance the scan after a clean cell or after its write command
   assign end_of_row = (32'(col_ff) == 32'(COLS - 1));

   always_comb begin
      addr_in        = addr_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      cursor_here_in = cursor_here_ff;
      if (ctrl.scan_start) begin
         addr_in        = '0;
         row_in         = '0;
         col_in         = '0;
         cursor_here_in = 1'b0;
      end else if ((ctrl.scan_check && !stat.differ) || ctrl.emit_write) begin
         addr_in        = addr_ff + AW'(1);
         cursor_here_in = ctrl.emit_write && !end_of_row;
         if (end_of_row) begin
            col_in = '0;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff        <= '0;
         row_ff         <= '0;
         col_ff         <= '0;
         cursor_here_ff <= 1'b0;
      end else begin
         addr_ff        <= addr_in;
         row_ff         <= row_in;
         col_ff         <= col_in;
         cursor_here_ff <= cursor_here_in;
      end
   end

   // Capture the new character of a changed cell
   always_ff @(posedge clock) begin
      if (ctrl.scan_check) begin
         char_ff <= wanted_char;
      end
   end

   // Queue a new command; the held one moves to the output register
   assign out_free = !out_valid_ff || rsp_ready;
   assign emit     = ctrl.emit_cursor || ctrl.emit_write;
   assign push     = emit && pend_valid_ff;
   assign out_load = push || (ctrl.flush && pend_valid_ff);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
      end else if (ctrl.flush) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit_cursor) begin
         pend_cmd_ff  <= CMD_CURSOR;
         pend_row_ff  <= ROW_W'(row_ff);
         pend_col_ff  <= COL_W'(col_ff);
         pend_char_ff <= '0;
      end else if (ctrl.emit_write) begin
         pend_cmd_ff  <= CMD_WRITE;
         pend_row_ff  <= '0;
         pend_col_ff  <= '0;
         pend_char_ff <= char_ff;
      end
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cmd_ff  <= pend_cmd_ff;
         out_row_ff  <= pend_row_ff;
         out_col_ff  <= pend_col_ff;
         out_char_ff <= pend_char_ff;
         out_last_ff <= ctrl.flush;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_command    = out_cmd_ff;
   assign rsp_cursor_row = out_row_ff;
   assign rsp_cursor_col = out_col_ff;
   assign rsp_out_char   = out_char_ff;
   assign rsp_last       = out_last_ff;

   // Status to the controller
   assign stat.differ      = (wanted_char != shown_char);
   assign stat.cursor_here = cursor_here_ff;
   assign stat.last_cell   = (32'(addr_ff) == 32'(CELLS - 1));
   assign stat.push_ok     = !pend_valid_ff || out_free;
   assign stat.pend_valid  = pend_valid_ff;
   assign stat.out_free    = out_free;

endmodule
`default_nettype wire

// File: sv/cdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdr_ctrl
// Controller: takes request items and sequences the refresh scan, one cell
// at a time, through read, compare and command steps.
// ----------------------------------------------------------------------------
module cdr_ctrl
   import cdr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_kind,
   output logic              req_ready,
   input  wire cdr_stat_type stat,
   output cdr_ctrl_type      ctrl
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_CURSOR = 3'd3;
   localparam logic [2:0] ST_WRITE  = 3'd4;
   localparam logic [2:0] ST_FLUSH  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_REFRESH) begin
                  ctrl.scan_start = 1'b1;
                  state_in        = ST_READ;
               end else begin
                  ctrl.wr_cell = 1'b1;
               end
            end
         end
         ST_READ: begin
            ctrl.scan_read = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            ctrl.scan_check = 1'b1;
            if (stat.differ) begin
               state_in = stat.cursor_here ? ST_WRITE : ST_CURSOR;
            end else begin
               state_in = stat.last_cell ? ST_FLUSH : ST_READ;
            end
         end
         ST_CURSOR: begin
            if (stat.push_ok) begin
               ctrl.emit_cursor = 1'b1;
               state_in         = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (stat.push_ok) begin
               ctrl.emit_write = 1'b1;
               state_in        = stat.last_cell ? ST_FLUSH : ST_READ;
            end
         end
         ST_FLUSH: begin
            // hold until the final command can enter the output register
            if (!stat.pend_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               ctrl.flush = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/character_display_dirty_refresh_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Store item: a new one accepted every cycle while no refresh is running, no result.
// Refresh item: accepted, then each grid cell is read and compared, each command is queued
//   and the final command is released; scan reads one cell per pass through the RAMs.
// Each command waits in the hold stage until the next command or the final flush moves it on.
// Reset: synchronous; both text stores read as spaces, no command pending.
// ----------------------------------------------------------------------------
// character_display_dirty_refresh_core
// Shadow-buffered character display refresh: sends cursor and write commands
// only for cells whose wanted text differs from the text already shown.
// ----------------------------------------------------------------------------
module character_display_dirty_refresh_core
   import cdr_pkg::*;
#(
   parameter int ROWS = 2,
   parameter int COLS = 16
) (
   input wire logic  clock,
   input wire logic  reset,
   cdr_req_if.sink   req_chan,
   cdr_rsp_if.source rsp_chan
);

   cdr_ctrl_type ctrl;
   cdr_stat_type stat;

   cdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   cdr_datapath #(.ROWS(ROWS), .COLS(COLS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .stat           (stat),
      .req_row        (req_chan.row),
      .req_col        (req_chan.col),
      .req_char_code  (req_chan.char_code),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_command    (rsp_chan.command),
      .rsp_cursor_row (rsp_chan.cursor_row),
      .rsp_cursor_col (rsp_chan.cursor_col),
      .rsp_out_char   (rsp_chan.out_char),
      .rsp_last       (rsp_chan.last)
   );

endmodule
`default_nettype wire

// File: dv/character_display_dirty_refresh_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// character_display_dirty_refresh_core_tb
// Drives cell stores and refresh requests into the core. A shadow model of
// the wanted and shown text predicts the cursor and write commands, and
// every command that leaves the core is checked in order against it.
// ----------------------------------------------------------------------------
module character_display_dirty_refresh_core_tb;
   import cdr_pkg::*;

   localparam int ROWS         = 2;
   localparam int COLS         = 16;
   localparam int CELLS        = ROWS * COLS;
   localparam int DIRECTED_N   = 22;
   localparam int RANDOM_ITEMS = 410;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT  = 1000000;

   // One display command as it leaves the core
   typedef struct packed {
      logic              command;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAR_W-1:0] ch;
      logic              last;
   } disp_cmd_type;

   // One request item, with commands typed in where they are obvious
   typedef struct packed {
      logic              kind;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CHAR_W-1:0] ch;
      logic              typed;
      logic [1:0]        n_exp;
      disp_cmd_type      exp0;
      disp_cmd_type      exp1;
   } stim_row_type;

   localparam disp_cmd_type NO_CMD = '0;

   logic clock;
   logic reset = 1'b1;

   cdr_req_if req_chan ();
   cdr_rsp_if rsp_chan ();

   character_display_dirty_refresh_core #(
      .ROWS(ROWS),
      .COLS(COLS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Shadow copies of the two text stores
   logic [CHAR_W-1:0] wanted_cells [CELLS];
   logic [CHAR_W-1:0] shown_cells  [CELLS];

   disp_cmd_type pending_cmds [$];
   disp_cmd_type scan_cmds    [$];

   int   mismatch_count = 0;
   int   accepted_items = 0;
   logic src_gaps = 1'b1;
   logic snk_gaps = 1'b1;

   // Directed items: reset contents, extremes, row edge, overwrite, no change
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b1, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd0,  8'h41, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b1, 4'd15, 8'hFF, 1'b1, 2'd2,
        '{CMD_CURSOR, 1'b0, 4'd0, 8'h00, 1'b0},
        '{CMD_WRITE,  1'b0, 4'd0, 8'h41, 1'b1}},
      '{KIND_STORE,   1'b1, 4'd15, 8'hFF, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b1, 2'd2,
        '{CMD_CURSOR, 1'b1, 4'd15, 8'h00, 1'b0},
        '{CMD_WRITE,  1'b0, 4'd0,  8'hFF, 1'b1}},
      '{KIND_STORE,   1'b0, 4'd0,  8'h41, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b1, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd1,  8'h00, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd2,  8'h7E, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd4,  8'h80, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd15, 8'h78, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b1, 4'd0,  8'h79, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b1, 4'd10, 8'h5A, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b1, 4'd5,  8'h55, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b1, 4'd5,  8'hAA, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b1, 4'd10, 8'h20, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b0, 4'd0,  8'h20, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_STORE,   1'b1, 4'd15, 8'h20, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b0, 4'd0,  8'h00, 1'b0, 2'd0, NO_CMD, NO_CMD},
      '{KIND_REFRESH, 1'b1, 4'd15, 8'hFF, 1'b1, 2'd0, NO_CMD, NO_CMD}
   };

   // Clock: 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walk the grid, emit commands for changed cells, update the shown copy
   function automatic void scan_dirty_cells();
      logic cur_known;
      int   cur_row;
      int   cur_col;
      int   idx;
      disp_cmd_type cmd;
      cur_known = 1'b0;
      cur_row   = 0;
      cur_col   = 0;
      scan_cmds.delete();
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) begin
            idx = r * COLS + c;
            if (wanted_cells[idx] != shown_cells[idx]) begin
               if (!cur_known || cur_row != r || cur_col != c) begin
                  cmd = '{CMD_CURSOR, ROW_W'(r), COL_W'(c), 8'h00, 1'b0};
                  scan_cmds.push_back(cmd);
                  cur_known = 1'b1;
                  cur_row   = r;
                  cur_col   = c;
               end
               cmd = '{CMD_WRITE, 1'b0, 4'd0, wanted_cells[idx], 1'b0};
               scan_cmds.push_back(cmd);
               shown_cells[idx] = wanted_cells[idx];
               cur_col++;
            end
         end
      end
      if (scan_cmds.size() > 0) scan_cmds[scan_cmds.size() - 1].last = 1'b1;
   endfunction

   // Offer one item, wait for its acceptance, then predict its commands
   task automatic drive_req(input stim_row_type item);
      int gap;
      gap = src_gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.kind      = item.kind;
      req_chan.row       = item.row;
      req_chan.col       = item.col;
      req_chan.char_code = item.ch;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      accepted_items++;
      if (item.kind == KIND_STORE) begin
         if (int'(item.row) < ROWS && int'(item.col) < COLS)
            wanted_cells[int'(item.row) * COLS + int'(item.col)] = item.ch;
      end else begin
         scan_dirty_cells();
         if (item.typed) begin
            if (item.n_exp > 0) pending_cmds.push_back(item.exp0);
            if (item.n_exp > 1) pending_cmds.push_back(item.exp1);
         end else begin
            foreach (scan_cmds[i]) pending_cmds.push_back(scan_cmds[i]);
         end
      end
      @(negedge clock);
   endtask

   // Favor the extreme codes and the reset space now and then
   function automatic logic [CHAR_W-1:0] pick_char();
      case ($urandom_range(0, 9))
         0: pick_char = 8'h00;
         1: pick_char = 8'hFF;
         2: pick_char = SPACE_CHAR;
         default: pick_char = CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_store(input int r, input int c, input logic [CHAR_W-1:0] ch);
      stim_row_type item;
      item = '{KIND_STORE, ROW_W'(r), COL_W'(c), ch, 1'b0, 2'd0, NO_CMD, NO_CMD};
      drive_req(item);
   endtask

   // Refresh with random filler in the unused fields
   task automatic send_refresh();
      stim_row_type item;
      item = '{KIND_REFRESH, ROW_W'($urandom_range(0, 1)), COL_W'($urandom_range(0, 15)),
               CHAR_W'($urandom_range(0, 255)), 1'b0, 2'd0, NO_CMD, NO_CMD};
      drive_req(item);
   endtask

   // Stimulus
   initial begin
      int pick;
      int n;
      int r;
      int c0;
      int idx;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_STORE;
      req_chan.row       = '0;
      req_chan.col       = '0;
      req_chan.char_code = '0;
      for (int i = 0; i < CELLS; i++) begin
         wanted_cells[i] = SPACE_CHAR;
         shown_cells[i]  = SPACE_CHAR;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table
      for (int i = 0; i < DIRECTED_N; i++) drive_req(directed_rows[i]);

      // Random screen updates, each mostly closed by a refresh
      while (accepted_items < DIRECTED_N + RANDOM_ITEMS) begin
         src_gaps = ($urandom_range(0, 3) != 0);
         snk_gaps = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            // scattered edits
            n = $urandom_range(1, 8);
            repeat (n) send_store($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                                  pick_char());
            send_refresh();
         end else if (pick < 60) begin
            // contiguous run in one row
            r  = $urandom_range(0, ROWS - 1);
            c0 = $urandom_range(0, COLS - 1);
            n  = $urandom_range(1, COLS - c0);
            for (int i = 0; i < n; i++) send_store(r, c0 + i, pick_char());
            send_refresh();
         end else if (pick < 68) begin
            // whole screen, the longest command burst
            for (int i = 0; i < CELLS; i++) send_store(i / COLS, i % COLS, pick_char());
            send_refresh();
         end else if (pick < 78) begin
            // change cells and put them back before the refresh
            n = $urandom_range(1, 6);
            repeat (n) begin
               idx = $urandom_range(0, CELLS - 1);
               send_store(idx / COLS, idx % COLS, pick_char());
               send_store(idx / COLS, idx % COLS, shown_cells[idx]);
            end
            send_refresh();
         end else if (pick < 90) begin
            // noise: any kind, any fields
            n = $urandom_range(1, 6);
            repeat (n) begin
               if ($urandom_range(0, 3) == 0) send_refresh();
               else send_store($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                               pick_char());
            end
         end else begin
            // edits followed by back-to-back refreshes
            n = $urandom_range(1, 10);
            repeat (n) send_store($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1),
                                  pick_char());
            send_refresh();
            send_refresh();
         end
      end
      req_chan.valid = 1'b0;

      // Drain outstanding commands, then watch for strays
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** character_display_dirty_refresh_core: PASSED **");
      else
         $display("** character_display_dirty_refresh_core: FAILED **");
      $finish;
   end

   // Result side: when gaps are on, ready may drop for a random stall before each item
   initial begin
      int stall;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = snk_gaps ? $urandom_range(0, 7) : 0;
         if (stall != 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         @(posedge clock);
         while (!rsp_chan.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [CHAR_W-1:0] want,
                                       input logic [CHAR_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted command with the oldest prediction
   always @(posedge clock) begin
      disp_cmd_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_cmds.size() == 0) begin
            $display("%0t ns: unexpected command, expected none, actual %0h %0h %0h %0h %0h",
                     $time, rsp_chan.command, rsp_chan.cursor_row, rsp_chan.cursor_col,
                     rsp_chan.out_char, rsp_chan.last);
            mismatch_count++;
         end else begin
            want = pending_cmds.pop_front();
            check_field("command",    want.command, rsp_chan.command);
            check_field("cursor_row", want.row,     rsp_chan.cursor_row);
            check_field("cursor_col", want.col,     rsp_chan.cursor_col);
            check_field("out_char",   want.ch,      rsp_chan.out_char);
            check_field("last",       want.last,    rsp_chan.last);
         end
      end
   end

   // Hang guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("%0t ns: cycle limit reached, %0d commands outstanding", $time,
               pending_cmds.size());
      $display("** character_display_dirty_refresh_core: FAILED **");
      $finish;
   end

endmodule

// File: character_display_dirty_refresh_core.f
sv/cdr_pkg.sv
sv/cdr_if.sv
sv/cdr_ram.sv
sv/cdr_datapath.sv
sv/cdr_ctrl.sv
sv/character_display_dirty_refresh_core.sv
dv/character_display_dirty_refresh_core_tb.sv
